@@ design/wtr_pkg.sv @@
// shared constants and types for the world-to-radar position core
// no dependencies

package wtr_pkg;

  localparam int MAG_W = 50;
  localparam int HW_W = 24;
  localparam int MR_W = 10;
  localparam int SQ_W = 30;
  localparam int SUM_W = 61;
  localparam int ROOT_W = 31;
  localparam int CQ_W = 17;
  localparam int POS_W = 15;

  localparam int DIV_LAT = MAG_W;
  localparam int ROOT_STEPS = 32;
  localparam int CDIV_STEPS = CQ_W;
  localparam int CLAMP_LAT = ROOT_STEPS + CDIV_STEPS;
  localparam int TOTAL_LAT = 8 + DIV_LAT + 4 + CLAMP_LAT + 4;

  localparam logic [1:0] CFG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] CFG_MAP_RADIUS = 2'd1;

  localparam logic [HW_W-1:0] HALF_WIDTH_RST = 24'd4096;
  localparam logic [MR_W-1:0] MAP_RADIUS_RST = 10'd128;

  typedef struct packed {
    logic clamp;
    logic un;
    logic vn;
  } side_a_t;

  typedef struct packed {
    logic             clamp;
    logic             un;
    logic             vn;
    logic             in_range;
    logic [MAG_W-1:0] mu;
    logic [MAG_W-1:0] mv;
  } side_b_t;

endpackage

@@ design/wtr_udiv.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on wtr_pkg

module wtr_udiv
  import wtr_pkg::*;
(
  input  logic             clk,
  input  logic [MAG_W-1:0] num,
  input  logic [HW_W-1:0]  den,
  output logic [MAG_W-1:0] quo
);

  logic [MAG_W-1:0] nm [0:DIV_LAT];
  logic [HW_W-1:0]  rm [0:DIV_LAT];
  logic [MAG_W-1:0] qo [0:DIV_LAT];

  assign nm[0] = num;
  assign rm[0] = '0;
  assign qo[0] = '0;

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
    logic [HW_W:0] trial;
    logic [HW_W:0] diff;
    assign trial = {rm[i], nm[i][MAG_W-1]};
    assign diff = trial - {1'b0, den};
    always_ff @(posedge clk) begin
      nm[i+1] <= {nm[i][MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rm[i+1] <= diff[HW_W-1:0];
        qo[i+1] <= {qo[i][MAG_W-2:0], 1'b1};
      end else begin
        rm[i+1] <= trial[HW_W-1:0];
        qo[i+1] <= {qo[i][MAG_W-2:0], 1'b0};
      end
    end
  end

  assign quo = qo[DIV_LAT];

endmodule

@@ design/wtr_clamp.sv @@
// border clamp: pipelined integer square root, then two pipelined
// divides of the shifted magnitudes by the root; depends on wtr_pkg

module wtr_clamp
  import wtr_pkg::*;
(
  input  logic              clk,
  input  logic [SQ_W-1:0]   su,
  input  logic [SQ_W-1:0]   sv,
  input  logic [SUM_W-1:0]  sum,
  output logic [CQ_W-1:0]   cu,
  output logic [CQ_W-1:0]   cv,
  output logic              root_zero
);

  logic [63:0]     iv  [0:ROOT_STEPS];
  logic [63:0]     ir  [0:ROOT_STEPS];
  logic [SQ_W-1:0] rsu [0:ROOT_STEPS];
  logic [SQ_W-1:0] rsv [0:ROOT_STEPS];

  assign iv[0] = {3'b0, sum};
  assign ir[0] = '0;
  assign rsu[0] = su;
  assign rsv[0] = sv;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = ir[k] + BIT;
    always_ff @(posedge clk) begin
      rsu[k+1] <= rsu[k];
      rsv[k+1] <= rsv[k];
      if (iv[k] >= trial) begin
        iv[k+1] <= iv[k] - trial;
        ir[k+1] <= (ir[k] >> 1) + BIT;
      end else begin
        iv[k+1] <= iv[k];
        ir[k+1] <= ir[k] >> 1;
      end
    end
  end

  logic [ROOT_W-1:0] dq [0:CDIV_STEPS];
  logic [46:0]       dn [0:1][0:CDIV_STEPS];
  logic [CQ_W-1:0]   qq [0:1][0:CDIV_STEPS];

  assign dq[0] = ir[ROOT_STEPS][ROOT_W-1:0];
  assign dn[0][0] = {1'b0, rsu[ROOT_STEPS], 16'b0};
  assign dn[1][0] = {1'b0, rsv[ROOT_STEPS], 16'b0};
  assign qq[0][0] = '0;
  assign qq[1][0] = '0;

  for (genvar j = 0; j < CDIV_STEPS; j++) begin : g_div
    localparam int SH = CDIV_STEPS - 1 - j;
    logic [46:0] dd;
    assign dd = 47'(dq[j]) << SH;
    always_ff @(posedge clk) begin
      dq[j+1] <= dq[j];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (dn[l][j] >= dd) begin
          dn[l][j+1] <= dn[l][j] - dd;
          qq[l][j+1] <= qq[l][j] | (CQ_W'(1) << SH);
        end else begin
          dn[l][j+1] <= dn[l][j];
          qq[l][j+1] <= qq[l][j];
        end
      end
    end
  end

  assign cu = qq[0][CDIV_STEPS];
  assign cv = qq[1][CDIV_STEPS];
  assign root_zero = (dq[CDIV_STEPS] == '0);

endmodule

@@ design/world_to_radar_position_core.sv @@
// world-to-radar position core: rotate, normalize, clamp and scale to pixels
// depends on wtr_pkg, wtr_udiv, wtr_clamp
//
// usage
//   a request is taken at a rising edge with start high and busy low; busy
//   is high only while rst is high, so a new request may enter every cycle
//   each request gives exactly one result: pos_x, pos_y and inside_res are
//   shown for one cycle with done high
//   throughput is one request per cycle; the latency is set by the two
//   bit-per-stage dividers by half_width (50 stages), the square root
//   (32 stages) and the border divides (17 stages)
//   the receiver cannot stall; results leave on their fixed cycle
//   registers are written over cfg_valid/cfg_ready with cfg_index and
//   cfg_data: index 0 half_width, index 1 map_radius, others ignored;
//   write them only while no request is in flight
//   rst clears all in-flight requests and loads half_width 4096 and
//   map_radius 128; cfg_ready is low during reset

module world_to_radar_position_core
  import wtr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic [15:0]        cam_yaw,
  input  logic               clamp_to_border,
  output logic               done,
  output logic [POS_W-1:0]   pos_x,
  output logic [POS_W-1:0]   pos_y,
  output logic               inside_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [HW_W-1:0]    cfg_data
);

  logic [HW_W-1:0] half_width;
  logic [MR_W-1:0] map_radius;

  assign busy = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RST;
      map_radius <= MAP_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_WIDTH: half_width <= cfg_data;
        CFG_MAP_RADIUS: map_radius <= cfg_data[MR_W-1:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic [7:0]           vld;
  logic [DIV_LAT-1:0]   vld_a;
  logic [3:0]           vld_n;
  logic [CLAMP_LAT-1:0] vld_b;
  logic [2:0]           vld_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vld_a <= '0;
      vld_n <= '0;
      vld_b <= '0;
      vld_p <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[6:0], start && !busy};
      vld_a <= {vld_a[DIV_LAT-2:0], vld[7]};
      vld_n <= {vld_n[2:0], vld_a[DIV_LAT-1]};
      vld_b <= {vld_b[CLAMP_LAT-2:0], vld_n[3]};
      vld_p <= {vld_p[1:0], vld_b[CLAMP_LAT-1]};
      done <= vld_p[2];
    end
  end

  // sine and cosine, lane 0 sin, lane 1 cos
  logic [15:0] ang [0:1];
  logic [14:0] tn  [0:1];

  always_comb begin
    ang[0] = cam_yaw;
    ang[1] = cam_yaw + 16'd16384;
    for (int l = 0; l < 2; l++) begin
      tn[l] = ang[l][14] ? (15'd16384 - {1'b0, ang[l][13:0]}) : {1'b0, ang[l][13:0]};
    end
  end

  logic signed [32:0] dx1, dy1, dx2, dy2, dx3, dy3, dx4, dy4, dx5, dy5;
  logic               cl1, cl2, cl3, cl4, cl5, cl6, cl7, cl8;
  logic [14:0]        t1 [0:1];
  logic [14:0]        t2 [0:1];
  logic [14:0]        t3 [0:1];
  logic [14:0]        t4 [0:1];
  logic               ng1 [0:1];
  logic               ng2 [0:1];
  logic               ng3 [0:1];
  logic               ng4 [0:1];
  logic [14:0]        x2 [0:1];
  logic [14:0]        x3 [0:1];
  logic [15:0]        inr [0:1];
  logic [16:0]        mid [0:1];
  logic [17:0]        sv5 [0:1];
  logic signed [17:0] sc [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sv5[l] = 18'((32'(mid[l]) * 32'(t4[l])) >> 14);
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= 33'(world_x) - 33'(cam_x);
    dy1 <= 33'(world_y) - 33'(cam_y);
    cl1 <= clamp_to_border;
    {dx2, dy2, cl2} <= {dx1, dy1, cl1};
    {dx3, dy3, cl3} <= {dx2, dy2, cl2};
    {dx4, dy4, cl4} <= {dx3, dy3, cl3};
    {dx5, dy5, cl5} <= {dx4, dy4, cl4};
    for (int l = 0; l < 2; l++) begin
      t1[l] <= tn[l];
      ng1[l] <= ang[l][15];
      x2[l] <= 15'((30'(t1[l]) * 30'(t1[l])) >> 14);
      t2[l] <= t1[l];
      ng2[l] <= ng1[l];
      inr[l] <= 16'(17'd42048 - 17'((28'd4640 * 28'(x2[l])) >> 14));
      x3[l] <= x2[l];
      t3[l] <= t2[l];
      ng3[l] <= ng2[l];
      mid[l] <= 17'(17'd102944 - 17'((31'(inr[l]) * 31'(x3[l])) >> 14));
      t4[l] <= t3[l];
      ng4[l] <= ng3[l];
      sc[l] <= ng4[l] ? -$signed(sv5[l]) : $signed(sv5[l]);
    end
  end

  // rotation
  logic signed [50:0] pxc, pys, pyc, pxs;
  logic signed [51:0] xr, yr;
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic               un8, vn8;

  always_ff @(posedge clk) begin
    pxc <= 51'(dx5) * 51'(sc[1]);
    pys <= 51'(dy5) * 51'(sc[0]);
    pyc <= 51'(dy5) * 51'(sc[1]);
    pxs <= 51'(dx5) * 51'(sc[0]);
    cl6 <= cl5;
    xr <= 52'(pxc) + 52'(pys);
    yr <= 52'(pyc) - 52'(pxs);
    cl7 <= cl6;
    mag_x <= xr[51] ? MAG_W'(-xr) : MAG_W'(xr);
    mag_y <= yr[51] ? MAG_W'(-yr) : MAG_W'(yr);
    un8 <= yr[51];
    vn8 <= !xr[51] && (xr != '0);
    cl8 <= cl7;
  end

  // normalize by half width
  logic [MAG_W-1:0] mu_q, mv_q;

  wtr_udiv u_div_u (.clk(clk), .num(mag_y), .den(half_width), .quo(mu_q));
  wtr_udiv u_div_v (.clk(clk), .num(mag_x), .den(half_width), .quo(mv_q));

  side_a_t dly_a [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    dly_a[0] <= '{clamp: cl8, un: un8, vn: vn8};
    for (int i = 1; i < DIV_LAT; i++) begin
      dly_a[i] <= dly_a[i-1];
    end
  end

  // distance test
  logic [MAG_W-1:0] orv;
  logic [4:0]       nsh;
  side_b_t          n1, n2, n3, n4;
  logic [4:0]       sh1;
  logic [SQ_W-1:0]  su2, sv2, su3, sv3, su4, sv4;
  logic             nz2, nz3;
  logic [59:0]      squ, sqv;
  logic [SUM_W-1:0] sum4;

  always_comb begin
    orv = mu_q | mv_q;
    nsh = '0;
    for (int i = SQ_W; i < MAG_W; i++) begin
      if (orv[i]) begin
        nsh = 5'(i - (SQ_W - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    n1 <= '{clamp: dly_a[DIV_LAT-1].clamp,
            un: dly_a[DIV_LAT-1].un && (mu_q != '0),
            vn: dly_a[DIV_LAT-1].vn && (mv_q != '0),
            in_range: 1'b0, mu: mu_q, mv: mv_q};
    sh1 <= nsh;
    n2 <= n1;
    su2 <= SQ_W'(n1.mu >> sh1);
    sv2 <= SQ_W'(n1.mv >> sh1);
    nz2 <= (sh1 != '0);
    n3 <= n2;
    squ <= 60'(su2) * 60'(su2);
    sqv <= 60'(sv2) * 60'(sv2);
    {su3, sv3, nz3} <= {su2, sv2, nz2};
    n4 <= '{clamp: n3.clamp, un: n3.un, vn: n3.vn,
            in_range: !nz3 && ((61'(squ) + 61'(sqv)) <= 61'h1_0000_0000),
            mu: n3.mu, mv: n3.mv};
    sum4 <= 61'(squ) + 61'(sqv);
    {su4, sv4} <= {su3, sv3};
  end

  // border clamp
  logic [CQ_W-1:0] cu, cv;
  logic            rz;

  wtr_clamp u_clamp (
    .clk(clk), .su(su4), .sv(sv4), .sum(sum4),
    .cu(cu), .cv(cv), .root_zero(rz)
  );

  side_b_t dly_b [0:CLAMP_LAT-1];

  always_ff @(posedge clk) begin
    dly_b[0] <= n4;
    for (int i = 1; i < CLAMP_LAT; i++) begin
      dly_b[i] <= dly_b[i-1];
    end
  end

  // pixel mapping
  side_b_t            fb;
  logic               use_c;
  logic [MAG_W-1:0]   mgu, mgv;
  logic signed [50:0] nu, nv;
  logic               in_p1, in_p2, in_p3;
  logic signed [61:0] pru, prv;
  logic signed [62:0] tot_u, tot_v;
  logic signed [62:0] rbase;
  logic [62:0]        rnd_u, rnd_v;

  always_comb begin
    fb = dly_b[CLAMP_LAT-1];
    use_c = fb.clamp && !fb.in_range && !rz;
    mgu = use_c ? MAG_W'(cu) : fb.mu;
    mgv = use_c ? MAG_W'(cv) : fb.mv;
    rbase = $signed({37'b0, map_radius, 16'b0});
    rnd_u = 63'(tot_u) + 63'd2048;
    rnd_v = 63'(tot_v) + 63'd2048;
  end

  always_ff @(posedge clk) begin
    nu <= fb.un ? -$signed({1'b0, mgu}) : $signed({1'b0, mgu});
    nv <= fb.vn ? -$signed({1'b0, mgv}) : $signed({1'b0, mgv});
    in_p1 <= fb.in_range;
    pru <= 62'(nu) * 62'($signed({1'b0, map_radius}));
    prv <= 62'(nv) * 62'($signed({1'b0, map_radius}));
    in_p2 <= in_p1;
    tot_u <= 63'(pru) + rbase;
    tot_v <= 63'(prv) + rbase;
    in_p3 <= in_p2;
    if (half_width == '0 || tot_u[62]) begin
      pos_x <= '0;
    end else if (rnd_u[62:12] > 51'd32767) begin
      pos_x <= '1;
    end else begin
      pos_x <= rnd_u[26:12];
    end
    if (half_width == '0 || tot_v[62]) begin
      pos_y <= '0;
    end else if (rnd_v[62:12] > 51'd32767) begin
      pos_y <= '1;
    end else begin
      pos_y <= rnd_v[26:12];
    end
    inside_res <= in_p3 && (half_width != '0);
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without matching request");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    done && (half_width == '0) |-> (pos_x == '0) && (pos_y == '0) && !inside_res)
    else $error("zero half width gave nonzero result");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    done && (map_radius == '0) |-> (pos_x == '0) && (pos_y == '0))
    else $error("zero radius gave nonzero position");

endmodule
